/* rtl/core/ssm_pkg.sv */
// Shared types, constants and helper functions of the sampler slot mapper.
package ssm_pkg;

    // Field widths of the fetch and result words.
    localparam int DIM_W    = 2;
    localparam int CLAMP_W  = 3;
    localparam int BCOL_W   = 2;
    localparam int FILT_W   = 2;
    localparam int ANISO_W  = 3;
    localparam int SLOT_W   = 4;
    localparam int ROUTE_W  = 2;
    localparam int MODE_W   = 3;
    localparam int KEY_W    = 15;

    // Dynamic table size and the slot of its first entry.
    localparam int DYN_ENTRIES = 3;
    localparam int DYN_IDX_W   = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1;
    localparam int DYN_CNT_W   = $clog2(DYN_ENTRIES + 1);
    localparam logic [SLOT_W-1:0] DYN_BASE_SLOT = 4'd13;

    // Static slots.
    localparam logic [SLOT_W-1:0] SLOT_POINT_WRAP  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_POINT_CLAMP = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_GRID_BASE   = 4'd4;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Texture dimension codes.
    localparam logic [DIM_W-1:0] DIM_1D   = 2'd0;
    localparam logic [DIM_W-1:0] DIM_2D   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_3D   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_CUBE = 2'd3;

    // Clamp codes.
    localparam logic [CLAMP_W-1:0] CLAMP_REPEAT        = 3'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_MIRROR        = 3'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_EDGE          = 3'd2;
    localparam logic [CLAMP_W-1:0] CLAMP_MIRROR_EDGE   = 3'd3;
    localparam logic [CLAMP_W-1:0] CLAMP_HALF          = 3'd4;
    localparam logic [CLAMP_W-1:0] CLAMP_MIRROR_HALF   = 3'd5;
    localparam logic [CLAMP_W-1:0] CLAMP_BORDER        = 3'd6;
    localparam logic [CLAMP_W-1:0] CLAMP_MIRROR_BORDER = 3'd7;

    // Addressing modes.
    localparam logic [MODE_W-1:0] AM_WRAP   = 3'd0;
    localparam logic [MODE_W-1:0] AM_MIRROR = 3'd1;
    localparam logic [MODE_W-1:0] AM_CLAMP  = 3'd2;
    localparam logic [MODE_W-1:0] AM_MONCE  = 3'd3;
    localparam logic [MODE_W-1:0] AM_BORDER = 3'd4;

    // Border color and filter codes.
    localparam logic [BCOL_W-1:0] BCOL_WHITE  = 2'd1;
    localparam logic [FILT_W-1:0] FILT_LINEAR = 2'd1;

    // Anisotropy code range that enables it.
    localparam logic [ANISO_W-1:0] ANISO_MIN = 3'd1;
    localparam logic [ANISO_W-1:0] ANISO_MAX = 3'd5;

    // How the slot was reached.
    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_STATIC   = 2'd0,
        ROUTE_HIT      = 2'd1,
        ROUTE_ALLOC    = 2'd2,
        ROUTE_FALLBACK = 2'd3
    } route_t;

    // Classified word passed from the front to the back part.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              exact;
        logic [SLOT_W-1:0] slot;
        logic              ycbcr;
    } front_word_t;

    // Folds a clamp code into its addressing mode.
    function automatic logic [MODE_W-1:0] mode_of_clamp(input logic [CLAMP_W-1:0] c);
        logic [MODE_W-1:0] m;
        begin
            case (c)
                CLAMP_REPEAT:        m = AM_WRAP;
                CLAMP_MIRROR:        m = AM_MIRROR;
                CLAMP_EDGE:          m = AM_CLAMP;
                CLAMP_MIRROR_EDGE:   m = AM_MONCE;
                CLAMP_HALF:          m = AM_CLAMP;
                CLAMP_MIRROR_HALF:   m = AM_MONCE;
                CLAMP_BORDER:        m = AM_BORDER;
                CLAMP_MIRROR_BORDER: m = AM_MONCE;
                default:             m = AM_CLAMP;
            endcase
            return m;
        end
    endfunction

    // Column or row of the static grid for one axis mode.
    function automatic logic [1:0] grid_axis(input logic [MODE_W-1:0] m);
        logic [1:0] g;
        begin
            if (m == AM_WRAP)
                g = 2'd0;
            else if (m == AM_MIRROR || m == AM_MONCE)
                g = 2'd1;
            else
                g = 2'd2;
            return g;
        end
    endfunction

    // True where a mode has an exact cell in the static grid.
    function automatic logic grid_exact(input logic [MODE_W-1:0] m);
        return (m == AM_WRAP) || (m == AM_MIRROR) || (m == AM_CLAMP);
    endfunction

endpackage

/* rtl/core/ssm_if.sv */
// Handshake channels of the sampler slot mapper: fetch words, result words, configuration.
interface ssm_fetch_if;
    logic                          valid;
    logic                          ready;
    logic [ssm_pkg::DIM_W-1:0]     dimension;
    logic [ssm_pkg::CLAMP_W-1:0]   clamp_x;
    logic [ssm_pkg::CLAMP_W-1:0]   clamp_y;
    logic [ssm_pkg::CLAMP_W-1:0]   clamp_z;
    logic [ssm_pkg::BCOL_W-1:0]    brd_color;
    logic [ssm_pkg::FILT_W-1:0]    min_filt;
    logic [ssm_pkg::FILT_W-1:0]    mag_filt;
    logic [ssm_pkg::ANISO_W-1:0]   aniso_code;

    modport source (
        output valid, dimension, clamp_x, clamp_y, clamp_z, brd_color,
               min_filt, mag_filt, aniso_code,
        input  ready
    );
    modport sink (
        input  valid, dimension, clamp_x, clamp_y, clamp_z, brd_color,
               min_filt, mag_filt, aniso_code,
        output ready
    );
endinterface

interface ssm_result_if;
    logic                          valid;
    logic                          ready;
    logic [ssm_pkg::SLOT_W-1:0]    slot;
    logic [ssm_pkg::ROUTE_W-1:0]   route;
    logic                          ycc_brd;

    modport source (output valid, slot, route, ycc_brd, input ready);
    modport sink   (input  valid, slot, route, ycc_brd, output ready);
endinterface

interface ssm_cfg_if;
    logic valid;
    logic ready;
    logic alloc_enable;

    modport source (output valid, alloc_enable, input ready);
    modport sink   (input  valid, alloc_enable, output ready);
endinterface

/* rtl/core/ssm_front.sv */
// Front part: takes fetch words, folds clamp modes and classifies each fetch.
module ssm_front (
    ssm_fetch_if.sink            fetch,
    output ssm_pkg::front_word_t word,
    output logic                 word_valid,
    input  logic                 word_ready
);
    import ssm_pkg::*;

    logic [CLAMP_W-1:0] cx;
    logic [CLAMP_W-1:0] cy;
    logic [CLAMP_W-1:0] cz;
    logic [MODE_W-1:0]  u;
    logic [MODE_W-1:0]  v;
    logic [MODE_W-1:0]  w;
    logic               min_lin;
    logic               mag_lin;
    logic               aniso;
    logic               brd_active;
    logic               white;
    logic               w_ok;
    logic [SLOT_W-1:0]  grid_slot;

    // The queue takes a word whenever it has room.
    assign fetch.ready = word_ready;
    assign word_valid  = fetch.valid;

    // Axes the dimension does not use, and all axes of a cube texture, are forced to clamp-to-edge.
    always_comb
    begin
        cx = CLAMP_EDGE;
        cy = CLAMP_EDGE;
        cz = CLAMP_EDGE;
        if (fetch.dimension == DIM_3D)
            cz = fetch.clamp_z;
        if (fetch.dimension == DIM_2D || fetch.dimension == DIM_3D)
            cy = fetch.clamp_y;
        if (fetch.dimension != DIM_CUBE)
            cx = fetch.clamp_x;
    end

    // Addressing modes and the flags that feed the key.
    always_comb
    begin
        u           = mode_of_clamp(cx);
        v           = mode_of_clamp(cy);
        w           = mode_of_clamp(cz);
        min_lin     = (fetch.min_filt == FILT_LINEAR);
        mag_lin     = (fetch.mag_filt == FILT_LINEAR);
        aniso       = (fetch.aniso_code >= ANISO_MIN) && (fetch.aniso_code <= ANISO_MAX);
        brd_active  = (u == AM_BORDER) || (v == AM_BORDER) || (w == AM_BORDER);
        white       = brd_active && (fetch.brd_color == BCOL_WHITE);
        w_ok        = (fetch.dimension != DIM_3D) || (w == v);
        grid_slot   = SLOT_GRID_BASE + SLOT_W'({grid_axis(u), 1'b0})
                    + SLOT_W'(grid_axis(u)) + SLOT_W'(grid_axis(v));
    end

    // Static slot match; a miss carries the grid slot as the fallback.
    always_comb
    begin
        word.exact = 1'b0;
        word.slot  = grid_slot;
        if (!aniso && !brd_active)
        begin
            if (min_lin && mag_lin && grid_exact(u) && grid_exact(v) && w_ok)
            begin
                word.exact = 1'b1;
            end
            else if (!min_lin && !mag_lin && (u == v) && w_ok)
            begin
                if (u == AM_WRAP)
                begin
                    word.exact = 1'b1;
                    word.slot  = SLOT_POINT_WRAP;
                end
                else if (u == AM_CLAMP)
                begin
                    word.exact = 1'b1;
                    word.slot  = SLOT_POINT_CLAMP;
                end
            end
        end
        word.ycbcr = brd_active && fetch.brd_color[1];
        word.key   = {(aniso ? fetch.aniso_code : ANISO_W'(0)), white, mag_lin, min_lin,
                      w, v, u};
    end

endmodule

/* rtl/core/ssm_queue.sv */
// Short queue of classified words between the front and back parts.
module ssm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssm_pkg::front_word_t push_word,
    input  logic                 push_valid,
    output logic                 push_ready,
    output ssm_pkg::front_word_t pop_word,
    output logic                 pop_valid,
    input  logic                 pop_ready
);
    import ssm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_word_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

endmodule

/* rtl/core/ssm_back.sv */
// Back part: dynamic key table lookup and allocation, result register.
module ssm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssm_pkg::front_word_t word,
    input  logic                 word_valid,
    output logic                 word_ready,
    ssm_cfg_if.sink              cfg,
    ssm_result_if.source         result
);
    import ssm_pkg::*;

    logic [KEY_W-1:0]     key_store_reg [DYN_ENTRIES];
    logic [DYN_CNT_W-1:0] used_cnt_reg;
    logic [DYN_CNT_W-1:0] used_cnt_next;
    logic                 alloc_enable_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    route_t               route_reg;
    route_t               route_next;
    logic                 ycbcr_reg;
    logic                 ycbcr_next;
    logic [DYN_ENTRIES-1:0] hit;
    logic [DYN_IDX_W-1:0] hit_idx;
    logic                 any_hit;
    logic                 room;
    logic                 do_alloc;
    logic                 take;

    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.slot    = slot_reg;
    assign result.route   = route_reg;
    assign result.ycc_brd = ycbcr_reg;

    // A word is taken when the result register is free or being emptied.
    assign word_ready = !out_valid_reg || result.ready;
    assign take       = word_valid && word_ready;

    // Parallel compare against the valid entries of the table.
    always_comb
    begin
        for (int i = 0; i < DYN_ENTRIES; i++)
            hit[i] = (DYN_CNT_W'(i) < used_cnt_reg) && (key_store_reg[i] == word.key);
        hit_idx = '0;
        for (int i = DYN_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
                hit_idx = DYN_IDX_W'(i);
        end
        any_hit = |hit;
    end

    // Slot and route selection for the word at the head of the queue.
    always_comb
    begin
        room           = (used_cnt_reg < DYN_CNT_W'(DYN_ENTRIES));
        do_alloc       = 1'b0;
        used_cnt_next  = used_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        slot_next      = slot_reg;
        route_next     = route_reg;
        ycbcr_next     = ycbcr_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            ycbcr_next     = word.ycbcr;
            if (word.exact)
            begin
                slot_next  = word.slot;
                route_next = ROUTE_STATIC;
            end
            else if (any_hit)
            begin
                slot_next  = DYN_BASE_SLOT + SLOT_W'(hit_idx);
                route_next = ROUTE_HIT;
            end
            else if (alloc_enable_reg && room)
            begin
                do_alloc      = 1'b1;
                used_cnt_next = used_cnt_reg + 1'b1;
                slot_next     = DYN_BASE_SLOT + SLOT_W'(used_cnt_reg);
                route_next    = ROUTE_ALLOC;
            end
            else
            begin
                slot_next  = word.slot;
                route_next = ROUTE_FALLBACK;
            end
        end
    end

    // Control state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_cnt_reg     <= '0;
            alloc_enable_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            slot_reg         <= '0;
            route_reg        <= ROUTE_STATIC;
            ycbcr_reg        <= 1'b0;
        end
        else
        begin
            used_cnt_reg  <= used_cnt_next;
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
            route_reg     <= route_next;
            ycbcr_reg     <= ycbcr_next;
            if (cfg.valid)
                alloc_enable_reg <= cfg.alloc_enable;
        end
    end

    // Write-once key table; entries past the fill count are never read.
    always_ff @(posedge clk)
    begin
        if (do_alloc)
            key_store_reg[used_cnt_reg[DYN_IDX_W-1:0]] <= word.key;
    end

endmodule

/* rtl/core/sampler_slot_mapper_unit.sv */
// Top level of the sampler slot mapper: front classifier, queue and table back end.
// A fetch word accepted by the front is written into the queue; when the back end takes it
// from the queue, its result word is held in the result register until it is taken.
// Throughput: one fetch word per cycle while results are taken; the table lookup is combinational.
// The two-entry queue lets the front keep accepting while a result waits to be taken.
// Reset empties the queue and the key table, drops the result and clears alloc_enable.
module sampler_slot_mapper_unit (
    input  logic          clk,
    input  logic          rst_n,
    ssm_fetch_if.sink     fetch,
    ssm_cfg_if.sink       cfg,
    ssm_result_if.source  result
);
    import ssm_pkg::*;

    front_word_t front_word;
    logic        front_valid;
    logic        front_ready;
    front_word_t back_word;
    logic        back_valid;
    logic        back_ready;

    // Classification of incoming fetch words.
    ssm_front u_front (
        .fetch      (fetch),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (front_ready)
    );

    // Decoupling queue.
    ssm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (back_word),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // Table lookup, allocation and result register.
    ssm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (back_word),
        .word_valid (back_valid),
        .word_ready (back_ready),
        .cfg        (cfg),
        .result     (result)
    );

endmodule
